// ===== hw/rtl/dta_pkg.sv =====
// dta_pkg: shared types and codes for the debounced threshold alarm
// no dependencies; used by every module of the block
package dta_pkg;

  localparam int unsigned SampleW  = 32;
  localparam int unsigned LimitW   = 31;
  localparam int unsigned CountW   = 8;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned EventW   = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OutDataW = 16;

  // mode codes
  localparam logic [ModeW-1:0] ModeNormal    = 2'd0;
  localparam logic [ModeW-1:0] ModeActive    = 2'd1;
  localparam logic [ModeW-1:0] ModeRecovered = 2'd2;

  // event codes
  localparam logic [EventW-1:0] EvtNone      = 2'd0;
  localparam logic [EventW-1:0] EvtTriggered = 2'd1;
  localparam logic [EventW-1:0] EvtRecovered = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegAlarmLimit    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTriggerCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRecoveryHyst  = 2'd2;

  typedef struct packed {
    logic [LimitW-1:0] alarm_limit;
    logic [CountW-1:0] trigger_count;
    logic [LimitW-1:0] recovery_hysteresis;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [CountW-1:0] count;
  } state_t;

  typedef struct packed {
    logic [CountW-1:0] over_count;
    logic [ModeW-1:0]  alarm_mode;
    logic [EventW-1:0] event_code;
  } result_t;

endpackage

// ===== hw/rtl/dta_cfg_regs.sv =====
// dta_cfg_regs: configuration register file of the alarm
// depends on dta_pkg
module dta_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dta_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dta_pkg::CfgDataW-1:0] cfg_data_i,
  output dta_pkg::cfg_t                cfg_o
);

  dta_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dta_pkg::RegAlarmLimit: begin
          cfg_d.alarm_limit = cfg_data_i[dta_pkg::LimitW-1:0];
        end
        dta_pkg::RegTriggerCount: begin
          cfg_d.trigger_count = cfg_data_i[dta_pkg::CountW-1:0];
        end
        dta_pkg::RegRecoveryHyst: begin
          cfg_d.recovery_hysteresis = cfg_data_i[dta_pkg::LimitW-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_limit         <= '0;
      cfg_q.trigger_count       <= 8'd3;
      cfg_q.recovery_hysteresis <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/dta_step.sv =====
// dta_step: compare and mode update for one sample
// depends on dta_pkg
module dta_step (
  input  logic [dta_pkg::SampleW-1:0] sample_i,
  input  dta_pkg::cfg_t               cfg_i,
  input  dta_pkg::state_t             state_i,
  output dta_pkg::state_t             state_o,
  output logic [dta_pkg::EventW-1:0]  event_o
);

  logic signed [dta_pkg::SampleW:0] sample_x;
  logic signed [dta_pkg::SampleW:0] limit_x;
  logic signed [dta_pkg::SampleW:0] low_bound;
  logic                             over;
  logic                             below;
  logic [dta_pkg::CountW-1:0]       count_inc;

  assign sample_x  = {sample_i[dta_pkg::SampleW-1], sample_i};
  assign limit_x   = {2'b00, cfg_i.alarm_limit};
  assign low_bound = limit_x - $signed({2'b00, cfg_i.recovery_hysteresis});
  assign over      = sample_x > limit_x;
  assign below     = sample_x < low_bound;
  assign count_inc = (state_i.count < cfg_i.trigger_count) ? state_i.count + 8'd1
                                                           : state_i.count;

  always_comb begin
    state_o = state_i;
    event_o = dta_pkg::EvtNone;
    unique case (state_i.mode)
      dta_pkg::ModeNormal: begin
        if (over) begin
          if (count_inc >= cfg_i.trigger_count) begin
            state_o.mode  = dta_pkg::ModeActive;
            state_o.count = cfg_i.trigger_count;
            event_o       = dta_pkg::EvtTriggered;
          end else begin
            state_o.count = count_inc;
          end
        end else begin
          state_o.count = '0;
        end
      end
      dta_pkg::ModeActive: begin
        if (below) begin
          state_o.mode  = dta_pkg::ModeRecovered;
          state_o.count = '0;
          event_o       = dta_pkg::EvtRecovered;
        end else begin
          state_o.count = cfg_i.trigger_count;
        end
      end
      default: begin
        // recovered, and the unused code
        state_o.mode  = dta_pkg::ModeNormal;
        state_o.count = over ? 8'd1 : 8'd0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/debounced_threshold_alarm_core.sv =====
// debounced_threshold_alarm_core: top level of the debounced threshold alarm
// a sample waits in the input register until the output register is free, then its result is registered there
// throughput: one sample per cycle while the output side does not stall, set by the mode update loop
// an input register and an output register part the two stream sides
// reset: mode normal, count 0, limit 0, trigger count 3, hysteresis 0
// depends on dta_pkg, dta_cfg_regs, dta_step
module debounced_threshold_alarm_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dta_pkg::SampleW-1:0]    s_axis_tdata,  // [31:0] sample_value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] event_code, [3:2] alarm_mode, [11:4] over_count, [15:12] zero
  output logic [dta_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dta_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dta_pkg::CfgDataW-1:0]   cfg_data_i
);

  dta_pkg::cfg_t   cfg;
  dta_pkg::state_t state_q, state_d;
  dta_pkg::result_t res_q, res_d;
  logic [dta_pkg::SampleW-1:0] sample_q;
  logic [dta_pkg::EventW-1:0]  evt;
  logic in_valid_q, out_valid_q;
  logic fire;

  dta_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dta_step u_step (
    .sample_i (sample_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_d),
    .event_o  (evt)
  );

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_comb begin
    res_d.event_code = evt;
    res_d.alarm_mode = state_d.mode;
    res_d.over_count = state_d.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.mode  <= dta_pkg::ModeNormal;
      state_q.count <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_q <= s_axis_tdata;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q};

  // a trigger always lands in active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.event_code == dta_pkg::EvtTriggered)
      |-> res_q.alarm_mode == dta_pkg::ModeActive)
    else $error("trigger without active mode");

  // a recovery lands in recovered with the count cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.event_code == dta_pkg::EvtRecovered)
      |-> (res_q.alarm_mode == dta_pkg::ModeRecovered) && (res_q.over_count == '0))
    else $error("recovery result malformed");

  // recovered lasts exactly one sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (state_q.mode == dta_pkg::ModeRecovered)
      |=> state_q.mode == dta_pkg::ModeNormal)
    else $error("recovered mode held past one sample");

  // the stored mode only moves when a sample is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(state_q))
    else $error("state changed without a transaction");

  // every processed sample leaves a result pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result lost");

endmodule
